// ----- hw/rtl/escd_pkg.sv -----
// ----------------------------------------------------------------------------
// escd_pkg
// Types, constants, microcode program and small tables for the seconds count
// to calendar date converter.
// ----------------------------------------------------------------------------
package escd_pkg;

    localparam int unsigned SEC_W  = 32;
    localparam int unsigned ZONE_W = 17;
    localparam int unsigned YEAR_W = 12;
    localparam int unsigned PACK_W = 31;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [YEAR_W-1:0] YEAR_1900    = 12'd1900;
    localparam logic [YEAR_W-1:0] YEAR_2000    = 12'd2000;
    localparam logic [YEAR_W-1:0] YEAR_2099    = 12'd2099;
    localparam logic [YEAR_W-1:0] YEAR_2100    = 12'd2100;

    // reciprocals of the odd factors 675, 225 and 15 after the power-of-two
    // factor is shifted off, rounded up so the quotient is exact in range
    localparam logic [25:0] RC_DAY   = 26'd50903317;
    localparam logic [13:0] RC_HOUR  = 14'd9321;
    localparam logic [10:0] RC_MIN   = 11'd1093;
    localparam int unsigned SH_DAY   = 35;
    localparam int unsigned SH_HOUR  = 21;
    localparam int unsigned SH_MIN   = 14;
    localparam logic [31:0] SECS_DAY  = 32'd86400;
    localparam logic [31:0] SECS_HOUR = 32'd3600;
    localparam logic [31:0] SECS_MIN  = 32'd60;

    localparam logic [PACK_W-1:0] PK_MON  = 31'd100000000;
    localparam logic [PACK_W-1:0] PK_DAY  = 31'd1000000;
    localparam logic [PACK_W-1:0] PK_HOUR = 31'd10000;
    localparam logic [PACK_W-1:0] PK_MIN  = 31'd100;

    localparam logic [3:0] LAST_MON = 4'd11;

    typedef logic [3:0] t_pc;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_QUOT,
        OP_REM,
        OP_SAVE_DAYS,
        OP_SAVE_HOUR,
        OP_SAVE_MIN,
        OP_YEAR,
        OP_MONTH,
        OP_PACK_MON,
        OP_PACK_DAY,
        OP_PACK_TIME,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        DS_DAY,
        DS_HOUR,
        DS_MIN
    } t_dsel;

    typedef enum logic [1:0] {
        CND_NEXT,
        CND_LOOP,
        CND_HOLD
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
        t_cond cond;
        t_pc   jmp;
    } t_uword;

    typedef struct packed {
        logic loop;
        logic hold;
    } t_ustat;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{OP_WAIT,      DS_DAY,  CND_HOLD, 4'd1};
            4'd1:    w = '{OP_QUOT,      DS_DAY,  CND_NEXT, 4'd0};
            4'd2:    w = '{OP_REM,       DS_DAY,  CND_NEXT, 4'd0};
            4'd3:    w = '{OP_SAVE_DAYS, DS_DAY,  CND_NEXT, 4'd0};
            4'd4:    w = '{OP_QUOT,      DS_HOUR, CND_NEXT, 4'd0};
            4'd5:    w = '{OP_REM,       DS_HOUR, CND_NEXT, 4'd0};
            4'd6:    w = '{OP_SAVE_HOUR, DS_HOUR, CND_NEXT, 4'd0};
            4'd7:    w = '{OP_QUOT,      DS_MIN,  CND_NEXT, 4'd0};
            4'd8:    w = '{OP_REM,       DS_MIN,  CND_NEXT, 4'd0};
            4'd9:    w = '{OP_SAVE_MIN,  DS_MIN,  CND_NEXT, 4'd0};
            4'd10:   w = '{OP_YEAR,      DS_DAY,  CND_LOOP, 4'd10};
            4'd11:   w = '{OP_MONTH,     DS_DAY,  CND_LOOP, 4'd11};
            4'd12:   w = '{OP_PACK_MON,  DS_DAY,  CND_NEXT, 4'd0};
            4'd13:   w = '{OP_PACK_DAY,  DS_DAY,  CND_NEXT, 4'd0};
            4'd14:   w = '{OP_PACK_TIME, DS_DAY,  CND_NEXT, 4'd0};
            4'd15:   w = '{OP_OUT,       DS_DAY,  CND_HOLD, 4'd0};
            default: w = '{OP_WAIT,      DS_DAY,  CND_HOLD, 4'd1};
        endcase
        return w;
    endfunction

    // exact over the reachable years 1970..2106
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'd0) && (y != YEAR_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] week_off(input logic [3:0] m);
        logic [2:0] w;
        case (m)
            4'd0, 4'd9:        w = 3'd0;
            4'd1, 4'd2, 4'd10: w = 3'd3;
            4'd3, 4'd6:        w = 3'd6;
            4'd4:              w = 3'd1;
            4'd5:              w = 3'd4;
            4'd7:              w = 3'd2;
            4'd8, 4'd11:       w = 3'd5;
            default:           w = 3'd0;
        endcase
        return w;
    endfunction

    // 8 is 1 mod 7, so fold octal digits
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s;
        logic [3:0] s2;
        s  = {3'd0, x[7:6]} + {2'd0, x[5:3]} + {2'd0, x[2:0]};
        s2 = {2'd0, s[4:3]} + {1'b0, s[2:0]};
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

// ----- hw/rtl/escd_useq.sv -----
// ----------------------------------------------------------------------------
// escd_useq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module escd_useq
    import escd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ustat i_stat,
    output t_uword o_cw
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        cw = ucode_rom(r_pc);
        case (cw.cond)
            CND_NEXT: n_pc = r_pc + 4'd1;
            CND_LOOP: n_pc = i_stat.loop ? cw.jmp : r_pc + 4'd1;
            CND_HOLD: n_pc = i_stat.hold ? r_pc : cw.jmp;
            default:  n_pc = '0;
        endcase
    end

    assign o_cw = cw;

    a_hold_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.cond == CND_HOLD && i_stat.hold) |=> (r_pc == $past(r_pc)))
        else $error("sequencer left a held step");

    a_loop_jumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.cond == CND_LOOP && i_stat.loop) |=> (r_pc == $past(cw.jmp)))
        else $error("sequencer missed a loop jump");

endmodule

// ----- hw/rtl/escd_dpath.sv -----
// ----------------------------------------------------------------------------
// escd_dpath
// Datapath: reciprocal multiply divider, year and month subtraction, weekday,
// packed decimal accumulation and the output register.
// ----------------------------------------------------------------------------
module escd_dpath
    import escd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_uword              i_cw,
    output t_ustat              o_stat,
    input  logic                i_cfg_wr_en,
    input  logic [ZONE_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SEC_W-1:0]    i_seconds_count,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [YEAR_W-1:0]   o_cal_year,
    output logic [3:0]          o_cal_month,
    output logic [4:0]          o_cal_day,
    output logic [4:0]          o_cal_hour,
    output logic [5:0]          o_cal_minute,
    output logic [5:0]          o_cal_second,
    output logic [2:0]          o_weekday,
    output logic                o_weekday_valid,
    output logic [PACK_W-1:0]   o_packed_decimal
);

    logic [ZONE_W-1:0] r_zone,  n_zone;
    logic [31:0]       r_rem,   n_rem;
    logic [15:0]       r_q,     n_q;
    logic [15:0]       r_days,  n_days;
    logic [YEAR_W-1:0] r_year,  n_year;
    logic [3:0]        r_mon,   n_mon;
    logic [4:0]        r_hour,  n_hour;
    logic [5:0]        r_min,   n_min;
    logic [5:0]        r_sec,   n_sec;
    logic [2:0]        r_wday,  n_wday;
    logic [PACK_W-1:0] r_acc,   n_acc;
    logic              r_o_valid, n_o_valid;
    logic [YEAR_W-1:0] r_o_year,  n_o_year;
    logic [3:0]        r_o_mon,   n_o_mon;
    logic [4:0]        r_o_day,   n_o_day;
    logic [4:0]        r_o_hour,  n_o_hour;
    logic [5:0]        r_o_min,   n_o_min;
    logic [5:0]        r_o_sec,   n_o_sec;
    logic [2:0]        r_o_wday,  n_o_wday;
    logic              r_o_wval,  n_o_wval;
    logic [PACK_W-1:0] r_o_pack,  n_o_pack;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        y_more;
    logic        m_more;
    logic [50:0] p_day;
    logic [26:0] p_hour;
    logic [20:0] p_min;
    logic [3:0]  mon1;
    logic [4:0]  day1;
    logic [7:0]  yl;
    logic [2:0]  w1;
    logic [5:0]  w2;
    logic        out_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_zone    <= n_zone;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_days   <= n_days;
        r_year   <= n_year;
        r_mon    <= n_mon;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
        r_wday   <= n_wday;
        r_acc    <= n_acc;
        r_o_year <= n_o_year;
        r_o_mon  <= n_o_mon;
        r_o_day  <= n_o_day;
        r_o_hour <= n_o_hour;
        r_o_min  <= n_o_min;
        r_o_sec  <= n_o_sec;
        r_o_wday <= n_o_wday;
        r_o_wval <= n_o_wval;
        r_o_pack <= n_o_pack;
    end

    always_comb begin
        leap     = is_leap(r_year);
        ylen     = leap ? 9'd366 : 9'd365;
        mlen     = month_len(r_mon, leap);
        y_more   = r_days >= {7'd0, ylen};
        m_more   = (r_mon < LAST_MON) && (r_days >= {11'd0, mlen});
        p_day    = 51'(r_rem[31:7]) * 51'(RC_DAY);
        p_hour   = 27'(r_rem[16:4]) * 27'(RC_HOUR);
        p_min    = 21'(r_rem[11:2]) * 21'(RC_MIN);
        mon1     = r_mon + 4'd1;
        day1     = r_days[4:0] + 5'd1;
        yl       = (r_year < YEAR_2100) ? 8'(r_year - YEAR_1900) : 8'(r_year - YEAR_2000);
        w1       = mod7(8'(yl + {2'd0, yl[7:2]}));
        w2       = {3'd0, w1} + {1'b0, day1} + {3'd0, week_off(r_mon)};
        if (yl[1:0] == 2'd0 && r_mon < 4'd2) begin
            w2 = w2 - 6'd1;
        end
        out_hold = r_o_valid && i_out_stall;

        n_zone    = i_cfg_wr_en ? i_cfg_wr_data : r_zone;
        n_rem     = r_rem;
        n_q       = r_q;
        n_days    = r_days;
        n_year    = r_year;
        n_mon     = r_mon;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_wday    = r_wday;
        n_acc     = r_acc;
        n_o_valid = out_hold;
        n_o_year  = r_o_year;
        n_o_mon   = r_o_mon;
        n_o_day   = r_o_day;
        n_o_hour  = r_o_hour;
        n_o_min   = r_o_min;
        n_o_sec   = r_o_sec;
        n_o_wday  = r_o_wday;
        n_o_wval  = r_o_wval;
        n_o_pack  = r_o_pack;
        o_stat    = '{loop: 1'b0, hold: 1'b0};

        case (i_cw.op)
            OP_WAIT: begin
                o_stat.hold = !i_in_valid;
                if (i_in_valid) begin
                    n_rem = i_seconds_count + {{(SEC_W-ZONE_W){1'b0}}, r_zone};
                end
            end
            OP_QUOT: begin
                case (i_cw.dsel)
                    DS_DAY: begin
                        n_q = 16'(p_day >> SH_DAY);
                    end
                    DS_HOUR: begin
                        n_q = 16'(p_hour >> SH_HOUR);
                    end
                    default: begin
                        n_q = 16'(p_min >> SH_MIN);
                    end
                endcase
            end
            OP_REM: begin
                case (i_cw.dsel)
                    DS_DAY: begin
                        n_rem = r_rem - {16'd0, r_q} * SECS_DAY;
                    end
                    DS_HOUR: begin
                        n_rem = r_rem - {16'd0, r_q} * SECS_HOUR;
                    end
                    default: begin
                        n_rem = r_rem - {16'd0, r_q} * SECS_MIN;
                    end
                endcase
            end
            OP_SAVE_DAYS: begin
                n_days = r_q;
                n_year = EPOCH_YEAR;
                n_mon  = '0;
            end
            OP_SAVE_HOUR: begin
                n_hour = r_q[4:0];
            end
            OP_SAVE_MIN: begin
                n_min = r_q[5:0];
                n_sec = r_rem[5:0];
            end
            OP_YEAR: begin
                o_stat.loop = y_more;
                if (y_more) begin
                    n_days = r_days - {7'd0, ylen};
                    n_year = r_year + 12'd1;
                end
            end
            OP_MONTH: begin
                o_stat.loop = m_more;
                if (m_more) begin
                    n_days = r_days - {11'd0, mlen};
                    n_mon  = r_mon + 4'd1;
                end
            end
            OP_PACK_MON: begin
                n_acc  = PACK_W'(mon1) * PK_MON;
                n_wday = mod7({2'd0, w2});
            end
            OP_PACK_DAY: begin
                n_acc = r_acc + PACK_W'(day1) * PK_DAY;
            end
            OP_PACK_TIME: begin
                n_acc = r_acc + PACK_W'(r_hour) * PK_HOUR + PACK_W'(r_min) * PK_MIN
                      + PACK_W'(r_sec);
            end
            OP_OUT: begin
                o_stat.hold = out_hold;
                if (!out_hold) begin
                    n_o_valid = 1'b1;
                    n_o_year  = r_year;
                    n_o_mon   = mon1;
                    n_o_day   = day1;
                    n_o_hour  = r_hour;
                    n_o_min   = r_min;
                    n_o_sec   = r_sec;
                    n_o_wday  = r_wday;
                    n_o_wval  = (r_year <= YEAR_2099);
                    n_o_pack  = r_acc;
                end
            end
            default: begin
                o_stat = '{loop: 1'b0, hold: 1'b0};
            end
        endcase
    end

    assign o_in_stall       = (i_cw.op != OP_WAIT);
    assign o_out_valid      = r_o_valid;
    assign o_cal_year       = r_o_year;
    assign o_cal_month      = r_o_mon;
    assign o_cal_day        = r_o_day;
    assign o_cal_hour       = r_o_hour;
    assign o_cal_minute     = r_o_min;
    assign o_cal_second     = r_o_sec;
    assign o_weekday        = r_o_wday;
    assign o_weekday_valid  = r_o_wval;
    assign o_packed_decimal = r_o_pack;

    a_year_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_MONTH) |-> (r_days < 16'd366))
        else $error("month search entered with more than a year of days");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_OUT) |-> (r_mon <= LAST_MON && r_hour <= 5'd23
                                 && r_min <= 6'd59 && r_sec <= 6'd59 && r_days < 16'd31))
        else $error("converted field out of range");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_OUT && !out_hold) |=> (r_o_valid && r_o_pack == $past(r_acc)))
        else $error("result item not loaded");

endmodule

// ----- hw/rtl/epoch_seconds_to_calendar_date_top.sv -----
// latency: an accepted item passes the day, hour and minute divide steps, the
// year and month loops (one subtraction per whole year past 1970 and per
// earlier month), the packing steps and the output load, held by output stall
// throughput: one item at a time; the year and month loops share one datapath
// reset: synchronous active-low; clears the zone offset, the step counter
// and the output valid
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_top
// Seconds count to calendar date, time of day, weekday and packed decimal.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_top
    import escd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ZONE_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SEC_W-1:0]    i_seconds_count,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [YEAR_W-1:0]   o_cal_year,
    output logic [3:0]          o_cal_month,
    output logic [4:0]          o_cal_day,
    output logic [4:0]          o_cal_hour,
    output logic [5:0]          o_cal_minute,
    output logic [5:0]          o_cal_second,
    output logic [2:0]          o_weekday,
    output logic                o_weekday_valid,
    output logic [PACK_W-1:0]   o_packed_decimal
);

    t_uword cw;
    t_ustat stat;

    escd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cw    (cw)
    );

    escd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cw             (cw),
        .o_stat           (stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_seconds_count  (i_seconds_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cal_year       (o_cal_year),
        .o_cal_month      (o_cal_month),
        .o_cal_day        (o_cal_day),
        .o_cal_hour       (o_cal_hour),
        .o_cal_minute     (o_cal_minute),
        .o_cal_second     (o_cal_second),
        .o_weekday        (o_weekday),
        .o_weekday_valid  (o_weekday_valid),
        .o_packed_decimal (o_packed_decimal)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the seconds count to calendar date converter.
// Seconds counts are sent in bursts under several zone offsets while the
// output side stalls on its own pattern; each result item is predicted
// from the count and offset and compared field by field, in order.
// ----------------------------------------------------------------------------
module tb
    import escd_pkg::*;
();

    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned SECS_PER_HOUR   = 3600;
    localparam int unsigned FIRST_YEAR      = 1970;
    localparam int unsigned LAST_YEAR       = 2106;
    localparam int unsigned WDAY_LAST_YEAR  = 2099;
    localparam int unsigned ZONE_MAX        = 131071;
    localparam int unsigned ZONE_UTC8       = 28800;
    localparam int unsigned ITEMS_PER_PHASE = 207;
    localparam int unsigned CFG_SETTLE      = 8;
    localparam int unsigned DRAIN_CYCLES    = 200;
    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned MAX_PRINTS      = 50;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEK_OFFSET [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct {
        logic [SEC_W-1:0]  src;
        logic [YEAR_W-1:0] yr;
        logic [3:0]        mon;
        logic [4:0]        mday;
        logic [4:0]        hr;
        logic [5:0]        mins;
        logic [5:0]        secs;
        logic [2:0]        wday;
        logic              wday_ok;
        logic [PACK_W-1:0] dec;
    } t_cal_rec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [ZONE_W-1:0]   i_cfg_wr_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [SEC_W-1:0]    i_seconds_count = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [YEAR_W-1:0]   o_cal_year;
    logic [3:0]          o_cal_month;
    logic [4:0]          o_cal_day;
    logic [4:0]          o_cal_hour;
    logic [5:0]          o_cal_minute;
    logic [5:0]          o_cal_second;
    logic [2:0]          o_weekday;
    logic                o_weekday_valid;
    logic [PACK_W-1:0]   o_packed_decimal;

    logic [ZONE_W-1:0]   zone_now = '0;
    logic [SEC_W-1:0]    stim_q[$];

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_days(int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(int unsigned m0, int unsigned y);
        if (m0 == 1 && leap_year(y)) begin
            return 29;
        end
        return MONTH_DAYS[m0];
    endfunction

    function automatic t_cal_rec to_calendar(logic [SEC_W-1:0] count, logic [ZONE_W-1:0] zone);
        t_cal_rec        r;
        logic [SEC_W-1:0] t;
        int unsigned     days, sod, yr, m, yl, w, mday, hr, mins, secs;
        longint unsigned dec;
        t = count + SEC_W'(zone);
        days = t / SECS_PER_DAY;
        sod = t % SECS_PER_DAY;
        yr = FIRST_YEAR;
        while (days >= year_days(yr)) begin
            days -= year_days(yr);
            yr++;
        end
        m = 0;
        while (m < 11 && days >= days_in_month(m, yr)) begin
            days -= days_in_month(m, yr);
            m++;
        end
        mday = days + 1;
        hr = sod / SECS_PER_HOUR;
        mins = (sod % SECS_PER_HOUR) / 60;
        secs = sod % 60;
        yl = yr % 100;
        if (yr / 100 > 19) begin
            yl += 100;
        end
        w = (yl + yl / 4) % 7 + mday + WEEK_OFFSET[m];
        if (yl % 4 == 0 && m < 2) begin
            w--;
        end
        dec = longint'(m + 1) * 100000000 + longint'(mday) * 1000000
            + longint'(hr) * 10000 + longint'(mins) * 100 + longint'(secs);
        r.src = count;
        r.yr = YEAR_W'(yr);
        r.mon = 4'(m + 1);
        r.mday = 5'(mday);
        r.hr = 5'(hr);
        r.mins = 6'(mins);
        r.secs = 6'(secs);
        r.wday = 3'(w % 7);
        r.wday_ok = (yr <= WDAY_LAST_YEAR);
        r.dec = PACK_W'(dec);
        return r;
    endfunction

    function automatic longint unsigned epoch_seconds(int unsigned yr, int unsigned m0);
        longint unsigned days;
        days = 0;
        for (int unsigned y = FIRST_YEAR; y < yr; y++) begin
            days += year_days(y);
        end
        for (int unsigned m = 0; m < m0; m++) begin
            days += days_in_month(m, yr);
        end
        return days * SECS_PER_DAY;
    endfunction

    // mostly counts near year and month boundaries, the rest random or near either end of the range
    function automatic logic [SEC_W-1:0] random_count();
        int unsigned pick, yr, m0;
        longint unsigned base;
        pick = $urandom_range(0, 99);
        yr = $urandom_range(FIRST_YEAR, LAST_YEAR);
        m0 = $urandom_range(0, 11);
        base = epoch_seconds(yr, (pick < 55) ? 0 : m0) + $urandom_range(0, 2 * SECS_PER_DAY)
             - SECS_PER_DAY;
        if (pick < 30) begin
            return $urandom;
        end
        if (pick < 85) begin
            return SEC_W'(base);
        end
        if (pick < 93) begin
            return $urandom_range(0, 400000);
        end
        return {SEC_W{1'b1}} - $urandom_range(0, 400000);
    endfunction

    class cal_scoreboard;
        t_cal_rec    pending[$];
        int unsigned errors;

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        function void note_input(logic [SEC_W-1:0] count, logic [ZONE_W-1:0] zone);
            pending.push_back(to_calendar(count, zone));
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want,
                           logic [SEC_W-1:0] src);
            if (got !== want) begin
                report($sformatf("count %0d: %s got %0d expected %0d", src, name, got, want));
            end
        endtask

        task check_result(t_cal_rec got);
            t_cal_rec want;
            if (pending.size() == 0) begin
                report("result item with no input pending");
            end else begin
                want = pending.pop_front();
                compare_field("year", got.yr, want.yr, want.src);
                compare_field("month", got.mon, want.mon, want.src);
                compare_field("day", got.mday, want.mday, want.src);
                compare_field("hour", got.hr, want.hr, want.src);
                compare_field("minute", got.mins, want.mins, want.src);
                compare_field("second", got.secs, want.secs, want.src);
                compare_field("weekday", got.wday, want.wday, want.src);
                compare_field("weekday_valid", got.wday_ok, want.wday_ok, want.src);
                compare_field("packed_decimal", got.dec, want.dec, want.src);
            end
        endtask
    endclass

    cal_scoreboard sb = new;

    epoch_seconds_to_calendar_date_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_seconds_count  (i_seconds_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cal_year       (o_cal_year),
        .o_cal_month      (o_cal_month),
        .o_cal_day        (o_cal_day),
        .o_cal_hour       (o_cal_hour),
        .o_cal_minute     (o_cal_minute),
        .o_cal_second     (o_cal_second),
        .o_weekday        (o_weekday),
        .o_weekday_valid  (o_weekday_valid),
        .o_packed_decimal (o_packed_decimal)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_stall_mode stall_mode = STALL_NONE;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 600);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_cal_rec got;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.src = '0;
            got.yr = o_cal_year;
            got.mon = o_cal_month;
            got.mday = o_cal_day;
            got.hr = o_cal_hour;
            got.mins = o_cal_minute;
            got.secs = o_cal_second;
            got.wday = o_weekday;
            got.wday_ok = o_weekday_valid;
            got.dec = o_packed_decimal;
            sb.check_result(got);
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_zone(logic [ZONE_W-1:0] v);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        zone_now = v;
    endtask

    task automatic add_random(int unsigned n);
        repeat (n) stim_q.push_back(random_count());
    endtask

    task automatic drive_counts();
        logic [SEC_W-1:0] x;
        int unsigned burst, gap, r;
        while (stim_q.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && stim_q.size() != 0) begin
                x = stim_q.pop_front();
                i_in_valid <= 1'b1;
                i_seconds_count <= x;
                @(posedge i_clk);
                while (o_in_stall !== 1'b0) @(posedge i_clk);
                sb.note_input(x, zone_now);
                burst--;
            end
            r = $urandom_range(0, 9);
            if (r < 3) begin
                gap = 0;
            end else if (r < 8) begin
                gap = $urandom_range(1, 20);
            end else begin
                gap = $urandom_range(20, 200);
            end
            if (gap != 0 || stim_q.size() == 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                // now and then, hold off until the converter has drained
                if (gap != 0 && $urandom_range(0, 19) == 0) begin
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        logic [SEC_W-1:0]  corner_counts [21];
        logic [ZONE_W-1:0] zone_plan [6];
        corner_counts = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd68169599,   // feb 28 1972, last second
            32'd68169600,   // feb 29 1972
            32'd94694399,   // dec 31 of a leap year, last second
            32'd94694400,
            32'd951782400,  // feb 29 2000
            32'd978307199,  // dec 31 2000, last second
            32'd4102444799, // last second of 2099
            32'd4102444800, // first second of 2100
            32'd4107542399, // feb 28 2100, no leap day follows
            32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
        };
        zone_plan = '{ZONE_W'(ZONE_MAX), ZONE_W'(1), ZONE_W'(SECS_PER_DAY - 1),
                      ZONE_W'(ZONE_UTC8), ZONE_W'(0),
                      ZONE_W'($urandom_range(0, ZONE_MAX))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_counts[i]) begin
            stim_q.push_back(corner_counts[i]);
        end
        add_random(ITEMS_PER_PHASE);
        drive_counts();

        foreach (zone_plan[p]) begin
            set_zone(zone_plan[p]);
            if (p == 0) begin
                // offset above one day, sum wraps past the top of the count
                stim_q.push_back(32'hFFFE_0001);
                stim_q.push_back(32'hFFFE_0000);
                stim_q.push_back(32'hFFFF_FFFF);
            end
            add_random(ITEMS_PER_PHASE);
            drive_counts();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/escd_pkg.sv
hw/rtl/escd_useq.sv
hw/rtl/escd_dpath.sv
hw/rtl/epoch_seconds_to_calendar_date_top.sv
dv/tb.sv
